[hdl/tks_pkg.sv]
// Shared types and constants of the topological sorter.
// Used by tks_deg_unit and topological_sort_kahn; no dependencies.
package tks_pkg;

  localparam int NODE_W        = 5;
  localparam int NC_W          = 6;
  localparam int IN_TDATA_W    = 16;
  localparam int OUT_TDATA_W   = 8;
  localparam int DEF_MAX_NODES = 32;
  localparam int DEF_MAX_EDGES = 256;
  localparam logic [NC_W-1:0] NC_RESET = 6'd32;

  typedef enum logic {
    OP_EDGE = 1'b0,
    OP_SORT = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_CYCLE   = 2'd1,
    STATUS_UNKNOWN = 2'd2
  } status_e;

  typedef struct packed {
    logic clear;
    logic step;
    logic dec;
  } deg_ctl_t;

  typedef struct packed {
    logic reached_zero;
  } deg_sts_t;

endpackage

[hdl/tks_deg_unit.sv]
// In-degree store with its shared increment/decrement unit and zero flags.
// Depends on tks_pkg.
module tks_deg_unit #(
  parameter int MAX_NODES = tks_pkg::DEF_MAX_NODES,
  parameter int MAX_EDGES = tks_pkg::DEF_MAX_EDGES
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  tks_pkg::deg_ctl_t        ctl_i,
  input  logic [$clog2(MAX_NODES)-1:0] rd_addr_i,
  input  logic [$clog2(MAX_NODES)-1:0] tgt_i,
  output logic [MAX_NODES-1:0]     zero_o,
  output tks_pkg::deg_sts_t        sts_o
);

  localparam int DW = $clog2(MAX_EDGES + 1);

  logic [DW-1:0]        deg_mem [MAX_NODES];
  logic [DW-1:0]        rd_q;
  logic [DW-1:0]        cur;
  logic [DW-1:0]        sum;
  logic                 apply;
  logic [MAX_NODES-1:0] zero_q;

  // a set zero flag overrides the stored count
  assign cur   = zero_q[tgt_i] ? '0 : rd_q;
  assign apply = ctl_i.step && (!ctl_i.dec || (cur != '0));
  assign sum   = ctl_i.dec ? (cur - DW'(1)) : (cur + DW'(1));

  always_ff @(posedge clk_i) begin
    if (apply) begin
      deg_mem[tgt_i] <= sum;
    end
    rd_q <= deg_mem[rd_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_q <= '1;
    end else if (ctl_i.clear) begin
      zero_q <= '1;
    end else if (apply) begin
      zero_q[tgt_i] <= (sum == '0);
    end
  end

  assign zero_o             = zero_q;
  assign sts_o.reached_zero = apply && ctl_i.dec && (sum == '0);

endmodule

[hdl/topological_sort_kahn.sv]
// Topological sorter (Kahn), lowest ready index first. Edge load: one edge per cycle.
// Sort run: an index check and an in-degree count over the stored edges, then for each
// placed node a ready scan and a relax pass over the edges, then the order is streamed
// out (or one error result); the single shared degree adder and one edge read a cycle
// bound the run time. Not ready during a run. Reset is asynchronous, active low, clears
// control state; edge and order memories are not cleared.
module topological_sort_kahn #(
  parameter int MAX_NODES = tks_pkg::DEF_MAX_NODES,
  parameter int MAX_EDGES = tks_pkg::DEF_MAX_EDGES
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [tks_pkg::IN_TDATA_W-1:0] s_axis_tdata_i,   // [4:0] from_node, [9:5] to_node
  input  logic [0:0]                     s_axis_tuser_i,   // [0] operation
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [tks_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,  // [4:0] node_index
  output logic [1:0]                     m_axis_tuser_o,   // [1:0] status
  output logic                           m_axis_tlast_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [tks_pkg::NC_W-1:0]       cfg_data_i
);

  localparam int NW  = $clog2(MAX_NODES);
  localparam int NW1 = $clog2(MAX_NODES + 1);
  localparam int EAW = $clog2(MAX_EDGES);
  localparam int ETW = $clog2(MAX_EDGES + 1);
  localparam int CW  = 8;
  localparam int NDW = tks_pkg::NODE_W;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_CHECK = 9'b000000010,
    S_COUNT = 9'b000000100,
    S_PREP  = 9'b000001000,
    S_PICK  = 9'b000010000,
    S_RELAX = 9'b000100000,
    S_FIN   = 9'b001000000,
    S_OUT   = 9'b010000000,
    S_ERR   = 9'b100000000
  } state_e;

  typedef enum logic [2:0] {
    PH_ADDR = 3'b001,
    PH_DATA = 3'b010,
    PH_DEG  = 3'b100
  } phase_e;

  state_e               state_q, state_d;
  phase_e               ph_q, ph_d;
  logic [tks_pkg::NC_W-1:0] nc_q;
  logic [NW1-1:0]       n_w;
  logic [MAX_NODES-1:0] nmask;
  logic [ETW-1:0]       total_q, total_d;
  logic                 bad_q, bad_d;
  logic                 bad_run_q, bad_run_d;
  logic [EAW-1:0]       e_q, e_d;
  logic [NW-1:0]        p_q, p_d;
  logic [NW-1:0]        pick_q, pick_d;
  logic [NW-1:0]        tgt_q, tgt_d;
  logic [NW1-1:0]       placed_q, placed_d;
  logic [NW-1:0]        k_q, k_d;
  logic [MAX_NODES-1:0] ready_q, ready_d;
  tks_pkg::status_e     err_q, err_d;
  logic                 out_valid_q, out_valid_d;
  logic [NDW-1:0]       out_node_q, out_node_d;
  tks_pkg::status_e     out_status_q, out_status_d;
  logic                 out_last_q, out_last_d;
  logic                 out_load;

  logic [2*NDW-1:0]     edge_mem [MAX_EDGES];
  logic [2*NDW-1:0]     edge_q;
  logic [NW-1:0]        order_mem [MAX_NODES];
  logic [NW-1:0]        ord_q;

  logic [NDW-1:0]       in_from, in_to, edge_from, edge_to;
  tks_pkg::op_e         in_op;
  logic                 accept, edge_we, order_we, edge_last, edge_bad, in_bad, out_free;

  tks_pkg::deg_ctl_t    deg_ctl;
  tks_pkg::deg_sts_t    deg_sts;
  logic [MAX_NODES-1:0] zero_mask;

  assign in_from   = s_axis_tdata_i[NDW-1:0];
  assign in_to     = s_axis_tdata_i[2*NDW-1:NDW];
  assign in_op     = tks_pkg::op_e'(s_axis_tuser_i[0]);
  assign edge_from = edge_q[NDW-1:0];
  assign edge_to   = edge_q[2*NDW-1:NDW];

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign cfg_ready_o     = (state_q == S_IDLE);
  assign accept    = s_axis_tvalid_i && s_axis_tready_o;
  assign edge_we   = accept && (in_op == tks_pkg::OP_EDGE) && (total_q < ETW'(MAX_EDGES));
  assign order_we  = (state_q == S_PICK) && ready_q[p_q];
  assign edge_last = ((ETW'(e_q) + ETW'(1)) == total_q);
  assign edge_bad  = (CW'(edge_from) >= CW'(n_w)) || (CW'(edge_to) >= CW'(n_w));
  assign in_bad    = (CW'(in_from) >= CW'(n_w)) || (CW'(in_to) >= CW'(n_w));
  assign out_free  = !out_valid_q || m_axis_tready_i;

  always_comb begin
    if (nc_q == '0) begin
      n_w = NW1'(1);
    end else if (CW'(nc_q) > CW'(MAX_NODES)) begin
      n_w = NW1'(MAX_NODES);
    end else begin
      n_w = NW1'(nc_q);
    end
    for (int i = 0; i < MAX_NODES; i++) begin
      nmask[i] = (CW'(i) < CW'(n_w));
    end
  end

  assign deg_ctl.clear = accept && (in_op == tks_pkg::OP_SORT);
  assign deg_ctl.step  = (ph_q == PH_DEG) && ((state_q == S_COUNT) || (state_q == S_RELAX));
  assign deg_ctl.dec   = (state_q == S_RELAX);

  tks_deg_unit #(
    .MAX_NODES(MAX_NODES),
    .MAX_EDGES(MAX_EDGES)
  ) u_deg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (deg_ctl),
    .rd_addr_i(NW'(edge_to)),
    .tgt_i    (tgt_q),
    .zero_o   (zero_mask),
    .sts_o    (deg_sts)
  );

  always_ff @(posedge clk_i) begin
    if (edge_we) begin
      edge_mem[total_q[EAW-1:0]] <= {in_to, in_from};
    end
    edge_q <= edge_mem[e_q];
    if (order_we) begin
      order_mem[placed_q[NW-1:0]] <= p_q;
    end
    ord_q <= order_mem[k_q];
  end

  always_comb begin
    state_d      = state_q;
    ph_d         = ph_q;
    total_d      = total_q;
    bad_d        = bad_q;
    bad_run_d    = bad_run_q;
    e_d          = e_q;
    p_d          = p_q;
    pick_d       = pick_q;
    tgt_d        = tgt_q;
    placed_d     = placed_q;
    k_d          = k_q;
    ready_d      = ready_q;
    err_d        = err_q;
    out_load     = 1'b0;
    out_node_d   = out_node_q;
    out_status_d = out_status_q;
    out_last_d   = out_last_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_op == tks_pkg::OP_EDGE) begin
            if (in_bad) begin
              bad_d = 1'b1;
            end
            if (edge_we) begin
              total_d = total_q + ETW'(1);
            end
          end else begin
            bad_run_d = bad_q;
            e_d       = '0;
            ph_d      = PH_ADDR;
            if (total_q != '0) begin
              state_d = S_CHECK;
            end else if (bad_q) begin
              err_d   = tks_pkg::STATUS_UNKNOWN;
              state_d = S_ERR;
            end else begin
              state_d = S_PREP;
            end
          end
        end
      end
      S_CHECK: begin
        if (ph_q == PH_ADDR) begin
          ph_d = PH_DATA;
        end else begin
          ph_d = PH_ADDR;
          if (edge_last) begin
            e_d = '0;
            if (bad_run_q || edge_bad) begin
              err_d   = tks_pkg::STATUS_UNKNOWN;
              state_d = S_ERR;
            end else begin
              state_d = S_COUNT;
            end
          end else begin
            bad_run_d = bad_run_q || edge_bad;
            e_d       = e_q + EAW'(1);
          end
        end
      end
      S_COUNT: begin
        case (ph_q)
          PH_ADDR: ph_d = PH_DATA;
          PH_DATA: begin
            tgt_d = NW'(edge_to);
            ph_d  = PH_DEG;
          end
          default: begin
            ph_d = PH_ADDR;
            if (edge_last) begin
              state_d = S_PREP;
            end else begin
              e_d = e_q + EAW'(1);
            end
          end
        endcase
      end
      S_PREP: begin
        ready_d  = zero_mask & nmask;
        placed_d = '0;
        p_d      = '0;
        state_d  = S_PICK;
      end
      S_PICK: begin
        if (ready_q[p_q]) begin
          ready_d[p_q] = 1'b0;
          pick_d       = p_q;
          placed_d     = placed_q + NW1'(1);
          e_d          = '0;
          ph_d         = PH_ADDR;
          p_d          = '0;
          if (total_q != '0) begin
            state_d = S_RELAX;
          end
        end else if ((NW1'(p_q) + NW1'(1)) == n_w) begin
          state_d = S_FIN;
        end else begin
          p_d = p_q + NW'(1);
        end
      end
      S_RELAX: begin
        case (ph_q)
          PH_ADDR: ph_d = PH_DATA;
          PH_DATA: begin
            if (CW'(edge_from) == CW'(pick_q)) begin
              tgt_d = NW'(edge_to);
              ph_d  = PH_DEG;
            end else begin
              ph_d = PH_ADDR;
              if (edge_last) begin
                state_d = S_PICK;
              end else begin
                e_d = e_q + EAW'(1);
              end
            end
          end
          default: begin
            if (deg_sts.reached_zero) begin
              ready_d[tgt_q] = 1'b1;
            end
            ph_d = PH_ADDR;
            if (edge_last) begin
              state_d = S_PICK;
            end else begin
              e_d = e_q + EAW'(1);
            end
          end
        endcase
      end
      S_FIN: begin
        if (placed_q == n_w) begin
          k_d     = '0;
          ph_d    = PH_ADDR;
          state_d = S_OUT;
        end else begin
          err_d   = tks_pkg::STATUS_CYCLE;
          state_d = S_ERR;
        end
      end
      S_OUT: begin
        if (ph_q == PH_ADDR) begin
          ph_d = PH_DATA;
        end else if (out_free) begin
          out_load     = 1'b1;
          out_node_d   = NDW'(ord_q);
          out_status_d = tks_pkg::STATUS_OK;
          out_last_d   = ((NW1'(k_q) + NW1'(1)) == n_w);
          ph_d         = PH_ADDR;
          if (out_last_d) begin
            total_d = '0;
            bad_d   = 1'b0;
            state_d = S_IDLE;
          end else begin
            k_d = k_q + NW'(1);
          end
        end
      end
      S_ERR: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_node_d   = '0;
          out_status_d = err_q;
          out_last_d   = 1'b1;
          total_d      = '0;
          bad_d        = 1'b0;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    out_valid_d = out_load || (out_valid_q && !m_axis_tready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ph_q        <= PH_ADDR;
      nc_q        <= tks_pkg::NC_RESET;
      total_q     <= '0;
      bad_q       <= 1'b0;
      bad_run_q   <= 1'b0;
      e_q         <= '0;
      p_q         <= '0;
      placed_q    <= '0;
      k_q         <= '0;
      ready_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ph_q        <= ph_d;
      if (cfg_valid_i && cfg_ready_o) begin
        nc_q <= cfg_data_i;
      end
      total_q     <= total_d;
      bad_q       <= bad_d;
      bad_run_q   <= bad_run_d;
      e_q         <= e_d;
      p_q         <= p_d;
      placed_q    <= placed_d;
      k_q         <= k_d;
      ready_q     <= ready_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pick_q       <= pick_d;
    tgt_q        <= tgt_d;
    err_q        <= err_d;
    out_node_q   <= out_node_d;
    out_status_q <= out_status_d;
    out_last_q   <= out_last_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(tks_pkg::OUT_TDATA_W - NDW){1'b0}}, out_node_q};
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tlast_o  = out_last_q;

`ifndef SYNTHESIS
  a_err_result_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tuser_o != tks_pkg::STATUS_OK))
      |-> (m_axis_tlast_o && (out_node_q == '0)))
    else $error("error result without last or with nonzero node");

  a_store_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q != S_IDLE) && (state_d == S_IDLE)) |=> ((total_q == '0) && !bad_q))
    else $error("edge store not cleared after a run");

  a_zero_only_relax: assert property (@(posedge clk_i) disable iff (!rst_ni)
    deg_sts.reached_zero |-> ((state_q == S_RELAX) && (ph_q == PH_DEG)))
    else $error("degree reached zero outside relax step");

  a_placed_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PICK) |-> (placed_q <= n_w))
    else $error("more nodes placed than in use");
`endif

endmodule
